[sv/alst_pkg.sv]
// Shared types, constants and helper functions of the access log status tally.
package alst_pkg;

  // Field widths.
  localparam int COUNT_W  = 40;
  localparam int TOTAL_W  = 48;
  localparam int STATUS_W = 14;
  localparam int TALLY_W  = 32;
  localparam int CLASS_W  = 2;
  localparam int PHASE_W  = 3;
  localparam int WIDE_W   = COUNT_W + TOTAL_W;

  // Configuration port geometry.
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ERROR   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SUCCESS = 1'b1;

  // Register reset values.
  localparam logic [STATUS_W-1:0] ERROR_RESET   = 14'd404;
  localparam logic [STATUS_W-1:0] SUCCESS_RESET = 14'd200;

  // Saturation limits.
  localparam logic [STATUS_W+2:0] STATUS_CAP_WIDE = 17'd9999;
  localparam logic [STATUS_W-1:0] STATUS_CAP      = 14'd9999;
  localparam logic [COUNT_W-1:0]  COUNT_CAP       = {COUNT_W{1'b1}};

  // Parser phases.
  localparam logic [PHASE_W-1:0] PH_SEARCH   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_S_START  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_S_SIGN   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_S_DIG    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_C_START  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_C_SIGN   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_C_DIG    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_FINISHED = 3'd7;

  // Line classes.
  localparam logic [CLASS_W-1:0] LC_NONE    = 2'd0;
  localparam logic [CLASS_W-1:0] LC_ERROR   = 2'd1;
  localparam logic [CLASS_W-1:0] LC_SUCCESS = 2'd2;
  localparam logic [CLASS_W-1:0] LC_OTHER   = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [TALLY_W-1:0]        error_count;
    logic signed [TOTAL_W-1:0] byte_total;
    logic [CLASS_W-1:0]        line_class;
  } out_item_t;

  // Parsed numbers of one finished line.
  typedef struct packed {
    logic                parsed;
    logic [STATUS_W-1:0] status_value;
    logic                status_negative;
    logic [COUNT_W-1:0]  count_value;
    logic                count_negative;
  } line_rec_t;

  // Configured status codes.
  typedef struct packed {
    logic [STATUS_W-1:0] error_status;
    logic [STATUS_W-1:0] success_status;
  } cfg_t;

  // Whitespace as the scanner sees it.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Decimal digit test.
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

endpackage

[sv/alst_cfg_regs.sv]
// APB-style register file holding the error and success status codes.
module alst_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alst_pkg::ADDR_W-1:0]  paddr,
  input  logic [alst_pkg::DATA_W-1:0]  pwdata,
  output logic [alst_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output alst_pkg::cfg_t               cfg
);
  import alst_pkg::*;

  logic [STATUS_W-1:0]  error_status_r;
  logic [STATUS_W-1:0]  success_status_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // Registers sit on word boundaries.
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_status_r   <= ERROR_RESET;
      success_status_r <= SUCCESS_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ERROR:   error_status_r   <= pwdata[STATUS_W-1:0];
        REG_SUCCESS: success_status_r <= pwdata[STATUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      REG_ERROR:   prdata = {{(DATA_W-STATUS_W){1'b0}}, error_status_r};
      REG_SUCCESS: prdata = {{(DATA_W-STATUS_W){1'b0}}, success_status_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.error_status   = error_status_r;
  assign cfg.success_status = success_status_r;

endmodule

[sv/alst_parser.sv]
// Input register and per-byte line parser that yields one record per line.
module alst_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  alst_pkg::in_item_t   in_data,
  output logic                 rec_valid,
  input  logic                 rec_ready,
  output alst_pkg::line_rec_t  rec
);
  import alst_pkg::*;

  logic                inq_valid_r;
  in_item_t            inq_r;
  logic                take;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                prior_r, prior_nxt;
  logic [STATUS_W-1:0] sval_r, sval_nxt;
  logic                sneg_r, sneg_nxt;
  logic [COUNT_W-1:0]  cval_r, cval_nxt;
  logic                cneg_r, cneg_nxt;

  logic                rec_valid_r;
  line_rec_t           rec_r;

  logic [7:0]          c;
  logic [3:0]          d;
  logic                c_space, c_digit, c_sign, c_minus;
  logic [STATUS_W+2:0] s_wide;
  logic [STATUS_W-1:0] s_acc;
  logic [COUNT_W+3:0]  c_wide;
  logic [COUNT_W-1:0]  c_acc;

  // A byte leaves the input register unless it ends a line and the record slot is full.
  assign take     = inq_valid_r && (!inq_r.line_end || !rec_valid_r || rec_ready);
  assign in_ready = !inq_valid_r || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_r <= in_data;
    end
  end

  // Character classes of the current byte.
  assign c       = inq_r.text_byte;
  assign d       = c[3:0];
  assign c_space = is_space(c);
  assign c_digit = is_digit(c);
  assign c_minus = (c == CH_MINUS);
  assign c_sign  = (c == CH_PLUS) || c_minus;

  // Status digit accumulate, saturating at the largest four-digit code.
  assign s_wide = {sval_r, 3'b000} + {2'b00, sval_r, 1'b0} + {{(STATUS_W-1){1'b0}}, d};
  assign s_acc  = (s_wide > STATUS_CAP_WIDE) ? STATUS_CAP : s_wide[STATUS_W-1:0];

  // Count digit accumulate, saturating at the field's full scale.
  assign c_wide = {1'b0, cval_r, 3'b000} + {3'b000, cval_r, 1'b0} + {{COUNT_W{1'b0}}, d};
  assign c_acc  = (c_wide[COUNT_W+3:COUNT_W] != 4'd0) ? COUNT_CAP : c_wide[COUNT_W-1:0];

  // Parser next state.
  always_comb begin
    phase_nxt = phase_r;
    prior_nxt = prior_r;
    sval_nxt  = sval_r;
    sneg_nxt  = sneg_r;
    cval_nxt  = cval_r;
    cneg_nxt  = cneg_r;
    if (phase_r != PH_FINISHED) begin
      if (c == CH_NUL) begin
        // A zero byte ends the text; a count already in digits still counts.
        phase_nxt = PH_FINISHED;
        prior_nxt = (phase_r == PH_C_DIG);
      end else begin
        unique case (phase_r)
          PH_SEARCH: begin
            if (prior_r && (c == CH_SPACE)) begin
              phase_nxt = PH_S_START;
              prior_nxt = 1'b0;
            end else begin
              prior_nxt = (c == CH_QUOTE);
            end
          end
          PH_S_START: begin
            if (c_space) begin
              phase_nxt = PH_S_START;
            end else if (c_sign) begin
              sneg_nxt  = c_minus;
              phase_nxt = PH_S_SIGN;
            end else if (c_digit) begin
              sval_nxt  = s_acc;
              phase_nxt = PH_S_DIG;
            end else begin
              phase_nxt = PH_FINISHED;
              prior_nxt = 1'b0;
            end
          end
          PH_S_SIGN: begin
            if (c_digit) begin
              sval_nxt  = s_acc;
              phase_nxt = PH_S_DIG;
            end else begin
              phase_nxt = PH_FINISHED;
              prior_nxt = 1'b0;
            end
          end
          PH_S_DIG: begin
            if (c_digit) begin
              sval_nxt = s_acc;
            end else if (c_space) begin
              phase_nxt = PH_C_START;
            end else if (c_sign) begin
              cneg_nxt  = c_minus;
              phase_nxt = PH_C_SIGN;
            end else begin
              phase_nxt = PH_FINISHED;
              prior_nxt = 1'b0;
            end
          end
          PH_C_START: begin
            if (c_space) begin
              phase_nxt = PH_C_START;
            end else if (c_sign) begin
              cneg_nxt  = c_minus;
              phase_nxt = PH_C_SIGN;
            end else if (c_digit) begin
              cval_nxt  = c_acc;
              phase_nxt = PH_C_DIG;
            end else begin
              phase_nxt = PH_FINISHED;
              prior_nxt = 1'b0;
            end
          end
          PH_C_SIGN: begin
            if (c_digit) begin
              cval_nxt  = c_acc;
              phase_nxt = PH_C_DIG;
            end else begin
              phase_nxt = PH_FINISHED;
              prior_nxt = 1'b0;
            end
          end
          PH_C_DIG: begin
            if (c_digit) begin
              cval_nxt = c_acc;
            end else begin
              phase_nxt = PH_FINISHED;
              prior_nxt = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_FINISHED;
            prior_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  // Parser state: cleared after the last byte of every line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      prior_r <= 1'b0;
      sval_r  <= '0;
      sneg_r  <= 1'b0;
      cval_r  <= '0;
      cneg_r  <= 1'b0;
    end else if (take) begin
      if (inq_r.line_end) begin
        phase_r <= PH_SEARCH;
        prior_r <= 1'b0;
        sval_r  <= '0;
        sneg_r  <= 1'b0;
        cval_r  <= '0;
        cneg_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        prior_r <= prior_nxt;
        sval_r  <= sval_nxt;
        sneg_r  <= sneg_nxt;
        cval_r  <= cval_nxt;
        cneg_r  <= cneg_nxt;
      end
    end
  end

  // Line record register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
    end else if (take && inq_r.line_end) begin
      rec_valid_r <= 1'b1;
    end else if (rec_ready) begin
      rec_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && inq_r.line_end) begin
      rec_r.parsed          <= (phase_nxt == PH_C_DIG) ||
                               ((phase_nxt == PH_FINISHED) && prior_nxt);
      rec_r.status_value    <= sval_nxt;
      rec_r.status_negative <= sneg_nxt;
      rec_r.count_value     <= cval_nxt;
      rec_r.count_negative  <= cneg_nxt;
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

[sv/alst_tally.sv]
// Status matching, running totals and the result register.
module alst_tally (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alst_pkg::cfg_t       cfg,
  input  logic                 rec_valid,
  output logic                 rec_ready,
  input  alst_pkg::line_rec_t  rec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output alst_pkg::out_item_t  out_data
);
  import alst_pkg::*;

  logic [TALLY_W-1:0] err_r, err_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [CLASS_W-1:0] cls;
  logic               out_valid_r;
  out_item_t          out_r;
  logic               move;
  logic               neg_blocks;
  logic               err_hit, suc_hit;
  logic [WIDE_W-1:0]  mag_w, neg_w;
  logic [TOTAL_W-1:0] delta;

  // A record moves on when the result register is free or being emptied.
  assign rec_ready = !out_valid_r || out_ready;
  assign move      = rec_valid && rec_ready;

  // A negative status matches only when its magnitude is zero.
  assign neg_blocks = rec.status_negative && (rec.status_value != '0);
  assign err_hit    = !neg_blocks && (rec.status_value == cfg.error_status);
  assign suc_hit    = !neg_blocks && (rec.status_value == cfg.success_status);

  // Signed byte count reduced to the total's width.
  assign mag_w = {{TOTAL_W{1'b0}}, rec.count_value};
  assign neg_w = {WIDE_W{1'b0}} - mag_w;
  assign delta = rec.count_negative ? neg_w[TOTAL_W-1:0] : mag_w[TOTAL_W-1:0];

  // Classification; the error code takes precedence.
  always_comb begin
    err_nxt = err_r;
    sum_nxt = sum_r;
    cls     = LC_NONE;
    if (rec.parsed) begin
      priority if (err_hit) begin
        err_nxt = err_r + 1'b1;
        cls     = LC_ERROR;
      end else if (suc_hit) begin
        sum_nxt = sum_r + delta;
        cls     = LC_SUCCESS;
      end else begin
        cls     = LC_OTHER;
      end
    end
  end

  // Running totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      sum_r <= '0;
    end else if (move) begin
      err_r <= err_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r.error_count <= err_nxt;
      out_r.byte_total  <= sum_nxt;
      out_r.line_class  <= cls;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sv/access_log_status_byte_tally_core.sv]
// Top level of the access log status tally.
//
// Log text enters one byte per item on the in_ channel (valid/ready), with
// line_end set on the last byte of each line. For every line the block finds
// the first quote followed by a space, reads a status and a byte count after
// it, and on the line's last byte delivers one item on the out_ channel with
// the running error count, the running byte total and the line's class.
// Bytes without line_end deliver nothing.
// Throughput is one byte per cycle while in_ready stays high. A line's last
// byte passes the input register and parser into the line record register,
// then the status match and total update into the result register.
// When the receiver stalls, the result register holds its item and the line
// record register behind it still takes one more line; bytes that do not end a
// line keep flowing, so in_ready falls only when a line's last byte finds both
// registers full.
// The status codes are set through the APB-style port (error code at 0x0,
// success code at 0x4). The codes must be written only while the block is idle;
// the block itself does not enforce this. Synchronous reset clears the parser,
// the totals and the valid flags and restores the codes to 404 and 200.
module access_log_status_byte_tally_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  alst_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output alst_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alst_pkg::ADDR_W-1:0]  paddr,
  input  logic [alst_pkg::DATA_W-1:0]  pwdata,
  output logic [alst_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import alst_pkg::*;

  cfg_t      cfg;
  logic      rec_valid;
  logic      rec_ready;
  line_rec_t rec;

  // Status code registers.
  alst_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Byte parser.
  alst_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // Totals and result register.
  alst_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/alst_checker.sv]
// Port-level checker for the access log status tally, with its bind statement.
module alst_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input alst_pkg::out_item_t  out_data
);
  import alst_pkg::*;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // With no result waiting the block always takes a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // The error count moves by one exactly on error lines.
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid |->
      (out_data.error_count == ((out_data.line_class == LC_ERROR) ?
        $past(out_data.error_count) + 1'b1 : $past(out_data.error_count))))
    else $error("error count out of step with the line class");

  // The byte total moves only on success lines.
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid && (out_data.line_class != LC_SUCCESS) |->
      out_data.byte_total == $past(out_data.byte_total))
    else $error("byte total changed on a line that is not a success line");

endmodule

bind access_log_status_byte_tally_core alst_checker u_alst_checker (.*);

[verif/tb_access_log_status_byte_tally_core.sv]
// Self-checking testbench for the access log status byte tally core.
`timescale 1ns / 1ps

module tb_access_log_status_byte_tally_core;
  import alst_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int BYTES_TARGET = 1950;
  localparam int N_PHASES     = 8;
  localparam int N_ROWS       = 14;
  localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_W) - 64'd1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic      pready;

  access_log_status_byte_tally_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Tally model state: the per-line scanner, the running totals and the codes.
  logic [PHASE_W-1:0]  scan_phase;
  logic                quote_or_ok;
  logic [STATUS_W-1:0] status_mag;
  logic                status_neg;
  logic [COUNT_W-1:0]  count_mag;
  logic                count_neg;
  logic [TALLY_W-1:0]  error_tally_m;
  logic [TOTAL_W-1:0]  byte_sum_m;
  logic [STATUS_W-1:0] error_code;
  logic [STATUS_W-1:0] success_code;

  // Results still owed by the block, oldest first.
  out_item_t pending_tallies[$];
  logic [7:0] line_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int items_fed = 0;
  int lines_checked = 0;
  int class_seen[4] = '{0, 0, 0, 0};

  // Directed lines; '@' stands for a zero byte. The last byte carries line_end.
  typedef struct {
    bit        typed;
    out_item_t val;
  } typed_row_t;

  string row_text[N_ROWS] = '{
    "a\" 404 9",
    "\" 200 -5",
    "\"\" +200\t+12 x",
    "no quote 404 1",
    "\" -",
    "\" 404",
    "\"x 404 1",
    "\" 99999 3",
    "\" -0 1",
    "\" 200 99999999999999",
    "\" 200 3@ 404 5",
    "\" 20@0 1",
    "@",
    "\377\" 404 -0"
  };

  typed_row_t row_expect[N_ROWS] = '{
    '{1'b1, '{32'd1, 48'sd0, LC_ERROR}},
    '{1'b1, '{32'd1, -48'sd5, LC_SUCCESS}},
    '{1'b0, '0},
    '{1'b1, '{32'd1, 48'sd7, LC_NONE}},
    '{1'b1, '{32'd1, 48'sd7, LC_NONE}},
    '{1'b1, '{32'd1, 48'sd7, LC_NONE}},
    '{1'b1, '{32'd1, 48'sd7, LC_NONE}},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0},
    '{1'b0, '0}
  };

  function automatic logic is_blank_ch(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit_ch(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic is_sign_ch(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic void restart_line();
    scan_phase  = PH_SEARCH;
    quote_or_ok = 1'b0;
    status_mag  = '0;
    status_neg  = 1'b0;
    count_mag   = '0;
    count_neg   = 1'b0;
  endfunction

  function automatic void close_scan(input logic ok);
    scan_phase  = PH_FINISHED;
    quote_or_ok = ok;
  endfunction

  // The status magnitude sticks at 9999 once it would pass it.
  function automatic void add_status_digit(input logic [7:0] c);
    int v;
    v = int'(status_mag) * 10 + int'(c - CH_DIG0);
    status_mag = (v > 9999) ? STATUS_CAP : STATUS_W'(v);
  endfunction

  // The count magnitude sticks at all ones of its width.
  function automatic void add_count_digit(input logic [7:0] c);
    longint unsigned d;
    longint unsigned cur;
    d = longint'(c - CH_DIG0);
    cur = count_mag;
    if (cur > (COUNT_SAT - d) / 10) count_mag = COUNT_CAP;
    else count_mag = COUNT_W'(cur * 10 + d);
  endfunction

  // One step of the per-line scanner.
  function automatic void scan_byte(input logic [7:0] c);
    if (scan_phase == PH_FINISHED) return;
    if (c == CH_NUL) begin
      close_scan(scan_phase == PH_C_DIG);
      return;
    end
    case (scan_phase)
      PH_SEARCH: begin
        if (quote_or_ok && c == CH_SPACE) begin
          scan_phase  = PH_S_START;
          quote_or_ok = 1'b0;
        end else begin
          quote_or_ok = (c == CH_QUOTE);
        end
      end
      PH_S_START: begin
        if (is_sign_ch(c)) begin
          status_neg = (c == CH_MINUS);
          scan_phase = PH_S_SIGN;
        end else if (is_digit_ch(c)) begin
          add_status_digit(c);
          scan_phase = PH_S_DIG;
        end else if (!is_blank_ch(c)) begin
          close_scan(1'b0);
        end
      end
      PH_S_SIGN: begin
        if (is_digit_ch(c)) begin
          add_status_digit(c);
          scan_phase = PH_S_DIG;
        end else begin
          close_scan(1'b0);
        end
      end
      PH_S_DIG: begin
        if (is_digit_ch(c)) begin
          add_status_digit(c);
        end else if (is_blank_ch(c)) begin
          scan_phase = PH_C_START;
        end else if (is_sign_ch(c)) begin
          count_neg  = (c == CH_MINUS);
          scan_phase = PH_C_SIGN;
        end else begin
          close_scan(1'b0);
        end
      end
      PH_C_START: begin
        if (is_sign_ch(c)) begin
          count_neg  = (c == CH_MINUS);
          scan_phase = PH_C_SIGN;
        end else if (is_digit_ch(c)) begin
          add_count_digit(c);
          scan_phase = PH_C_DIG;
        end else if (!is_blank_ch(c)) begin
          close_scan(1'b0);
        end
      end
      PH_C_SIGN: begin
        if (is_digit_ch(c)) begin
          add_count_digit(c);
          scan_phase = PH_C_DIG;
        end else begin
          close_scan(1'b0);
        end
      end
      PH_C_DIG: begin
        if (is_digit_ch(c)) add_count_digit(c);
        else close_scan(1'b1);
      end
      default: close_scan(1'b0);
    endcase
  endfunction

  // A negative status can only match through a zero magnitude.
  function automatic logic status_hits(input logic [STATUS_W-1:0] code);
    if (status_neg && status_mag != '0) return 1'b0;
    return status_mag == code;
  endfunction

  // Advances the model by one byte; returns 1 with the result on a line end.
  function automatic logic tally_item(input in_item_t it, output out_item_t res);
    logic               parsed;
    logic [CLASS_W-1:0] cls;
    logic [TOTAL_W-1:0] mag_w;
    res = '0;
    scan_byte(it.text_byte);
    if (!it.line_end) return 1'b0;
    parsed = (scan_phase == PH_C_DIG) || (scan_phase == PH_FINISHED && quote_or_ok);
    cls = LC_NONE;
    if (parsed) begin
      if (status_hits(error_code)) begin
        error_tally_m = error_tally_m + 1'b1;
        cls = LC_ERROR;
      end else if (status_hits(success_code)) begin
        mag_w = TOTAL_W'(count_mag);
        byte_sum_m = count_neg ? byte_sum_m - mag_w : byte_sum_m + mag_w;
        cls = LC_SUCCESS;
      end else begin
        cls = LC_OTHER;
      end
    end
    res.error_count = error_tally_m;
    res.byte_total  = byte_sum_m;
    res.line_class  = cls;
    restart_line();
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_blank();
    int sel;
    sel = $urandom_range(5);
    return (sel == 5) ? CH_SPACE : 8'(CH_TAB + sel);
  endfunction

  // Builds one random line: mostly well formed, some cut short, some noise.
  task automatic compose_line();
    int kind;
    int sel;
    int n;
    int unsigned v;
    logic has_sep;
    string digits;
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind >= 85) begin
      n = $urandom_range(1, 20);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
    if ($urandom_range(3) == 0) line_buf.push_back(CH_QUOTE);
    line_buf.push_back(CH_QUOTE);
    line_buf.push_back(CH_SPACE);
    repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
    // Status, leaning towards the configured codes.
    sel = $urandom_range(9);
    if (sel == 0) line_buf.push_back(CH_MINUS);
    else if (sel < 3) line_buf.push_back(CH_PLUS);
    sel = $urandom_range(9);
    if (sel < 3) v = error_code;
    else if (sel < 6) v = success_code;
    else if (sel == 6) v = 0;
    else if (sel == 7) v = $urandom_range(10000, 999999);
    else v = $urandom_range(9999);
    if ($urandom_range(7) == 0) line_buf.push_back(CH_DIG0);
    digits = $sformatf("%0d", v);
    foreach (digits[i]) line_buf.push_back(digits[i]);
    // Separator, then the byte count with an optional sign.
    has_sep = ($urandom_range(9) != 0);
    if (has_sep) repeat ($urandom_range(1, 2)) line_buf.push_back(pick_blank());
    sel = $urandom_range(9);
    if (sel < 2 || !has_sep) line_buf.push_back(CH_MINUS);
    else if (sel < 4) line_buf.push_back(CH_PLUS);
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
    repeat (n) line_buf.push_back(8'(CH_DIG0 + $urandom_range(9)));
    // Tail after the count.
    case ($urandom_range(3))
      0: ;
      1: begin
        line_buf.push_back(pick_blank());
        repeat ($urandom_range(0, 5)) line_buf.push_back(8'($urandom_range(255)));
      end
      2: begin
        line_buf.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(255)));
      end
      default: line_buf.push_back(8'($urandom_range(255)));
    endcase
    if (kind >= 70) begin
      n = $urandom_range(1, line_buf.size());
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
  endtask

  // Offers one item, waits for it to be taken and records what it should produce.
  task automatic deliver(input in_item_t it, input logic use_typed, input out_item_t typed_val);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_fed++;
    if (tally_item(it, predicted)) pending_tallies.push_back(use_typed ? typed_val : predicted);
  endtask

  // Register write: setup phase, access phase, then the bus is left idle.
  task automatic write_code(input logic [REG_IDX_W-1:0] idx, input logic [STATUS_W-1:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom << STATUS_W) | DATA_W'(code);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ERROR) error_code = code;
    else success_code = code;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker and activity counter for the watchdog.
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_tallies.size() == 0) begin
          $error("unexpected result item: error_count %0d byte_total %0d line_class %0d",
                 got.error_count, got.byte_total, got.line_class);
          mismatches++;
        end else begin
          want = pending_tallies.pop_front();
          lines_checked++;
          class_seen[want.line_class]++;
          if (got.error_count !== want.error_count) begin
            $error("error_count: expected %0d, got %0d", want.error_count, got.error_count);
            mismatches++;
          end
          if (got.byte_total !== want.byte_total) begin
            $error("byte_total: expected %0d, got %0d", want.byte_total, got.byte_total);
            mismatches++;
          end
          if (got.line_class !== want.line_class) begin
            $error("line_class: expected %0d, got %0d", want.line_class, got.line_class);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving ends the run.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_access_log_status_byte_tally_core: done, errors");
    $finish;
  end

  initial begin
    in_item_t item;
    string txt;
    int per_phase;
    int phase_start;
    logic [STATUS_W-1:0] e_code;
    logic [STATUS_W-1:0] s_code;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    error_code    = ERROR_RESET;
    success_code  = SUCCESS_RESET;
    error_tally_m = '0;
    byte_sum_m    = '0;
    restart_line();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines under the reset codes.
    foreach (row_text[r]) begin
      txt = row_text[r];
      for (int i = 0; i < txt.len(); i++) begin
        item.text_byte = (txt[i] == "@") ? CH_NUL : txt[i];
        item.line_end  = (i == txt.len() - 1);
        deliver(item, row_expect[r].typed, row_expect[r].val);
      end
    end

    // Random lines, one code setting and one idling pattern per phase.
    per_phase = (BYTES_TARGET - items_fed) / N_PHASES;
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin e_code = 14'd0;     s_code = 14'd0;     end
        1: begin e_code = 14'd9999;  s_code = 14'd16383; end
        2: begin e_code = 14'd16383; s_code = 14'd9999;  end
        4: begin e_code = ERROR_RESET; s_code = SUCCESS_RESET; end
        5: begin
          e_code = 14'($urandom_range(9999));
          s_code = e_code;
        end
        6: begin e_code = 14'($urandom_range(9999)); s_code = 14'd0; end
        default: begin
          e_code = 14'($urandom_range(9999));
          s_code = 14'($urandom_range(9999));
        end
      endcase
      write_code(REG_ERROR, e_code);
      write_code(REG_SUCCESS, s_code);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      phase_start = items_fed;
      while (items_fed - phase_start < per_phase) begin
        compose_line();
        foreach (line_buf[i]) begin
          item.text_byte = line_buf[i];
          item.line_end  = (i == line_buf.size() - 1);
          deliver(item, 1'b0, '0);
        end
      end
    end
    drain();

    $display("Fed %0d text bytes through %0d code settings and four idling patterns;",
             items_fed, N_PHASES + 1);
    $display("checked %0d lines: %0d unparsed, %0d error, %0d success, %0d other status.",
             lines_checked, class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
    if (mismatches == 0) begin
      $display("tb_access_log_status_byte_tally_core: done, clean");
    end else begin
      $display("tb_access_log_status_byte_tally_core: done, errors");
    end
    $finish;
  end

endmodule

[access_log_status_byte_tally_core.f]
sv/alst_pkg.sv
sv/alst_cfg_regs.sv
sv/alst_parser.sv
sv/alst_tally.sv
sv/access_log_status_byte_tally_core.sv
sv/alst_checker.sv
verif/tb_access_log_status_byte_tally_core.sv
